// ----- src/trpd_pkg.sv -----
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants of the run-length coded pixel stream decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  // default upper bound on image width and height
  localparam int DEF_MAX_DIM = 4096;

  // hard cap given by the 12-bit coordinate fields
  localparam int COORD_CAP = 4096;

  // configuration register indexes
  localparam logic [2:0] CFG_BPP         = 3'd0;
  localparam logic [2:0] CFG_WIDTH       = 3'd1;
  localparam logic [2:0] CFG_HEIGHT      = 3'd2;
  localparam logic [2:0] CFG_TOP_FIRST   = 3'd3;
  localparam logic [2:0] CFG_RIGHT_FIRST = 3'd4;

  // configuration write data width (widest register)
  localparam int CFG_DW = 13;

  // register reset values
  localparam logic [2:0]  RST_BPP    = 3'd4;
  localparam logic [12:0] RST_WIDTH  = 13'd4096;
  localparam logic [12:0] RST_HEIGHT = 13'd4096;

  // raw configuration register contents
  typedef struct packed {
    logic [2:0]  bpp;
    logic [12:0] width;
    logic [12:0] height;
    logic        top_first;
    logic        right_first;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic seg_load;  // compute next segment into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_req;  // accepted word completes a pixel that must be placed
    logic seg_last;  // segment being loaded is the final one of the pixel
  } status_t;

endpackage

// ----- src/trpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// trpd_ctrl
// Controller: input handshake, segment issue sequencing and output valid.
// ----------------------------------------------------------------------------
module trpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  trpd_pkg::status_t st,
  output trpd_pkg::cmd_t    cmd
);
  import trpd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // handshake and commands
  assign in_tready    = (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_tready;
  assign cmd.accept   = in_tvalid && in_tready;
  assign cmd.seg_load = (state_r == S_EMIT) && out_free;
  assign out_tvalid   = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && st.emit_req) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.seg_load && st.seg_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd.seg_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_load |=> out_tvalid)
    else $error("segment load did not raise output valid");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_load && st.seg_last |=> in_tready)
    else $error("final segment did not return to input");

  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.seg_load)
    else $error("segment load while taking input");
`endif

endmodule

// ----- src/trpd_dpath.sv -----
// ----------------------------------------------------------------------------
// trpd_dpath
// Datapath: packet parsing, pixel assembly, scan position and row segments.
// ----------------------------------------------------------------------------
module trpd_dpath #(
  parameter int MAX_DIM = trpd_pkg::DEF_MAX_DIM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  trpd_pkg::cfg_t     cfg,
  input  trpd_pkg::cmd_t     cmd,
  output trpd_pkg::status_t  st,
  input  logic [7:0]         in_byte,
  input  logic               in_sof,
  output logic [31:0]        out_value,
  output logic [11:0]        out_x,
  output logic [11:0]        out_y,
  output logic [7:0]         out_run,
  output logic               out_done,
  output logic               out_last
);
  import trpd_pkg::*;

  localparam int          DimCap  = (MAX_DIM < COORD_CAP) ? MAX_DIM : COORD_CAP;
  localparam logic [12:0] DimMax  = 13'(DimCap);
  localparam logic [11:0] RstRow  = 12'(DimCap - 1);

  // decoder state
  logic        expect_r, expect_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [11:0] cur_x_r, cur_x_nxt;
  logic [11:0] cur_y_r, cur_y_nxt;
  logic [12:0] rows_r, rows_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  nrem_r, nrem_nxt;
  logic [31:0] value_r, value_nxt;

  // output register
  logic [31:0] o_value_r;
  logic [11:0] o_x_r, o_y_r;
  logic [7:0]  o_run_r;
  logic        o_done_r, o_last_r;

  // effective configuration
  logic [12:0] eff_w, eff_h;
  logic [2:0]  eff_bpp;
  logic [11:0] start_col, start_row;

  // accept path
  logic        hdr_eff, rep_eff, fin_eff;
  logic [1:0]  bidx_eff;
  logic [7:0]  left_eff, n_pix;
  logic [31:0] gather_eff, gather_or;
  logic [2:0]  bidx_inc;
  logic        pix_done;

  // segment path
  logic [12:0] cx13, room, n13, seg13, rows_inc;
  logic [7:0]  seg, rem_after;
  logic        row_end, seg_done;

  // clamp registers into range
  always_comb begin
    eff_w = cfg.width;
    if (eff_w > DimMax) eff_w = DimMax;
    if (eff_w < 13'd4)  eff_w = 13'd4;
    eff_h = cfg.height;
    if (eff_h > DimMax) eff_h = DimMax;
    if (eff_h < 13'd1)  eff_h = 13'd1;
    eff_bpp = cfg.bpp;
    if (eff_bpp < 3'd1) eff_bpp = 3'd1;
    if (eff_bpp > 3'd4) eff_bpp = 3'd4;
  end

  assign start_col = cfg.right_first ? 12'(eff_w - 13'd1) : 12'd0;
  assign start_row = cfg.top_first   ? 12'd0 : 12'(eff_h - 13'd1);

  // byte parsing, with a restart folded in
  assign hdr_eff    = in_sof ? 1'b1  : expect_r;
  assign rep_eff    = in_sof ? 1'b0  : repeat_r;
  assign fin_eff    = in_sof ? 1'b0  : fin_r;
  assign bidx_eff   = in_sof ? 2'd0  : bidx_r;
  assign left_eff   = in_sof ? 8'd0  : left_r;
  assign gather_eff = in_sof ? 32'd0 : gather_r;
  assign gather_or  = gather_eff | (32'(in_byte) << {bidx_eff, 3'b000});
  assign bidx_inc   = {1'b0, bidx_eff} + 3'd1;
  assign pix_done   = !hdr_eff && (bidx_inc >= eff_bpp);

  always_comb begin
    n_pix = rep_eff ? left_eff : 8'd1;
    if (n_pix == 8'd0) n_pix = 8'd1;
  end

  assign st.emit_req = pix_done && !fin_eff;

  // segment of the current run that fits in the row
  assign cx13 = {1'b0, cur_x_r};
  assign n13  = {5'b0, nrem_r};
  always_comb begin
    if (cfg.right_first) begin
      room = cx13 + 13'd1;
    end else if (cx13 < eff_w) begin
      room = eff_w - cx13;
    end else begin
      room = 13'd1;
    end
  end
  assign seg13     = (n13 < room) ? n13 : room;
  assign seg       = seg13[7:0];
  assign row_end   = (n13 >= room);
  assign rows_inc  = rows_r + 13'd1;
  assign seg_done  = row_end && (rows_inc >= eff_h);
  assign rem_after = nrem_r - seg;
  assign st.seg_last = (rem_after == 8'd0) || seg_done;

  // next state
  always_comb begin
    expect_nxt = expect_r;
    repeat_nxt = repeat_r;
    left_nxt   = left_r;
    bidx_nxt   = bidx_r;
    gather_nxt = gather_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    rows_nxt   = rows_r;
    fin_nxt    = fin_r;
    nrem_nxt   = nrem_r;
    value_nxt  = value_r;
    if (cmd.accept) begin
      // restart to the start position of the current orientation
      if (in_sof) begin
        cur_x_nxt = start_col;
        cur_y_nxt = start_row;
        rows_nxt  = 13'd0;
        fin_nxt   = 1'b0;
      end
      if (hdr_eff) begin
        repeat_nxt = in_byte[7];
        left_nxt   = {1'b0, in_byte[6:0]} + 8'd1;
        bidx_nxt   = 2'd0;
        gather_nxt = 32'd0;
        expect_nxt = 1'b0;
      end else if (!pix_done) begin
        repeat_nxt = rep_eff;
        left_nxt   = left_eff;
        bidx_nxt   = bidx_inc[1:0];
        gather_nxt = gather_or;
        expect_nxt = 1'b0;
      end else begin
        repeat_nxt = rep_eff;
        value_nxt  = gather_or;
        gather_nxt = 32'd0;
        bidx_nxt   = 2'd0;
        nrem_nxt   = n_pix;
        left_nxt   = (left_eff > n_pix) ? left_eff - n_pix : 8'd0;
        expect_nxt = !(left_eff > n_pix);
      end
    end else if (cmd.seg_load) begin
      nrem_nxt = seg_done ? 8'd0 : rem_after;
      if (row_end) begin
        cur_x_nxt = start_col;
        cur_y_nxt = cfg.top_first ? cur_y_r + 12'd1 : cur_y_r - 12'd1;
        rows_nxt  = rows_inc;
        if (seg_done) fin_nxt = 1'b1;
      end else if (cfg.right_first) begin
        cur_x_nxt = cur_x_r - {4'b0, seg};
      end else begin
        cur_x_nxt = cur_x_r + {4'b0, seg};
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b1;
      repeat_r <= 1'b0;
      left_r   <= 8'd0;
      bidx_r   <= 2'd0;
      gather_r <= 32'd0;
      cur_x_r  <= 12'd0;
      cur_y_r  <= RstRow;
      rows_r   <= 13'd0;
      fin_r    <= 1'b0;
      nrem_r   <= 8'd0;
    end else begin
      expect_r <= expect_nxt;
      repeat_r <= repeat_nxt;
      left_r   <= left_nxt;
      bidx_r   <= bidx_nxt;
      gather_r <= gather_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      rows_r   <= rows_nxt;
      fin_r    <= fin_nxt;
      nrem_r   <= nrem_nxt;
    end
  end

  // pixel word and output payload
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (cmd.seg_load) begin
      o_value_r <= value_r;
      o_x_r     <= cur_x_r;
      o_y_r     <= cur_y_r;
      o_run_r   <= seg;
      o_done_r  <= seg_done;
      o_last_r  <= st.seg_last;
    end
  end

  assign out_value = o_value_r;
  assign out_x     = o_x_r;
  assign out_y     = o_y_r;
  assign out_run   = o_run_r;
  assign out_done  = o_done_r;
  assign out_last  = o_last_r;

`ifndef SYNTH
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_load |-> (seg != 8'd0) && (seg <= nrem_r))
    else $error("segment length out of range");

  a_done_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_load && seg_done |=> fin_r)
    else $error("image done without finish flag");

  a_more_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_load && !st.seg_last |=> (nrem_r != 8'd0) && !fin_r)
    else $error("run continues with nothing left");
`endif

endmodule

// ----- src/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length coded TGA pixel stream decoder producing row segments.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                         tuser / tlast
//  in_      in   [7:0] data_byte                               tuser start_of_image
//  out_     out  [31:0] value [43:32] x [55:44] y [63:56] run  tuser image_done,
//                                                              tlast last_of_item
//  cfg_     in   we, addr = register index, wdata [12:0]       -
//
// A header byte or a byte inside a pixel leaves the input ready for the next
// byte. A byte that completes a pixel, unless the image is done, is followed by
// its row segments from the segment unit (at most 33), input held meanwhile.
// Output stalls hold the segment unit; no clearing pass after reset. Synchronous active-low
// reset returns control, decoder and config registers to their reset values, not pixel word or payload.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int MAX_DIM = trpd_pkg::DEF_MAX_DIM
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // data_byte
  input  logic [0:0]                 in_tuser,   // start_of_image
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // pixel_value, pixel_x, pixel_y, run_length
  output logic [0:0]                 out_tuser,  // image_done
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [trpd_pkg::CFG_DW-1:0] cfg_wdata
);
  import trpd_pkg::*;

  cfg_t        cfg_r;
  cmd_t        cmd;
  status_t     st;
  logic [31:0] o_value;
  logic [11:0] o_x, o_y;
  logic [7:0]  o_run;
  logic        o_done, o_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp         <= RST_BPP;
      cfg_r.width       <= RST_WIDTH;
      cfg_r.height      <= RST_HEIGHT;
      cfg_r.top_first   <= 1'b0;
      cfg_r.right_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BPP:         cfg_r.bpp         <= cfg_wdata[2:0];
        CFG_WIDTH:       cfg_r.width       <= cfg_wdata[12:0];
        CFG_HEIGHT:      cfg_r.height      <= cfg_wdata[12:0];
        CFG_TOP_FIRST:   cfg_r.top_first   <= cfg_wdata[0];
        CFG_RIGHT_FIRST: cfg_r.right_first <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // controller
  trpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath
  trpd_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (in_tdata),
    .in_sof    (in_tuser[0]),
    .out_value (o_value),
    .out_x     (o_x),
    .out_y     (o_y),
    .out_run   (o_run),
    .out_done  (o_done),
    .out_last  (o_last)
  );

  // output packing
  assign out_tdata = {o_run, o_y, o_x, o_value};
  assign out_tuser = o_done;
  assign out_tlast = o_last;

endmodule
